// ----- hdl/gpra_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpra_pkg: shared types and constants
// Widths, item and result records, page record layout and sequencer states
// for the guest physical region access checker.
// ----------------------------------------------------------------------------
package gpra_pkg;

	localparam int MaxRegions     = 4;
	localparam int RegIdxBits     = 2;
	localparam int PagesPerRegion = 256;
	localparam int PageIdxBits    = 8;
	localparam int NPageBits      = 9;
	localparam int PageShift      = 12;
	localparam int AddrBits       = 48;
	localparam int GenBits        = 32;
	localparam int OffBits        = PageShift + PageIdxBits;
	localparam int PageAddrBits   = RegIdxBits + PageIdxBits;
	localparam int PageDepth      = MaxRegions * PagesPerRegion;

	// One past the highest address: a region may end exactly here.
	localparam logic [AddrBits+1:0] AddrSpan = {2'b01, {AddrBits{1'b0}}};

	typedef enum logic [2:0] {
		OP_ADD_RAM,
		OP_ADD_ROM,
		OP_ADD_DEV,
		OP_READ,
		OP_WRITE,
		OP_FETCH,
		OP_MARK,
		OP_NONE
	} op_t;

	typedef enum logic [2:0] {
		FAULT_NONE,
		FAULT_UNMAPPED,
		FAULT_PERM,
		FAULT_MMIO,
		FAULT_REJECT
	} fault_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ADD,
		S_FILL,
		S_FIND,
		S_EVAL,
		S_PG_RD,
		S_PG_WB,
		S_EMIT
	} seq_state_t;

	typedef struct packed {
		op_t               op;
		logic [AddrBits-1:0] address;
		logic [AddrBits:0]   region_size;
		logic [3:0]        access_len;
		logic [3:0]        device_id;
	} item_t;

	typedef struct packed {
		logic               code;
		logic               dirty;
		logic               exec;
		logic [GenBits-1:0] gen;
	} page_t;

	typedef struct packed {
		fault_t                fault;
		logic [AddrBits-1:0]   fault_addr;
		logic                  write_access;
		logic                  fetch_access;
		logic [RegIdxBits-1:0] region_index;
		logic                  is_device;
		logic [3:0]            target_device;
		logic [AddrBits-1:0]   offset;
		logic [3:0]            chunk_len;
		logic                  code_invalidated;
		logic                  last;
	} result_t;

endpackage
`default_nettype wire

// ----- hdl/gpra_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpra_front: input acceptance and classification
// Takes items from the input channel, decodes the kind into an operation and
// holds them in a two-entry queue for the sequencer.
// ----------------------------------------------------------------------------
module gpra_front (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [2:0]                    kind,
	input  wire logic [gpra_pkg::AddrBits-1:0] address,
	input  wire logic [gpra_pkg::AddrBits:0]   region_size,
	input  wire logic [3:0]                    access_len,
	input  wire logic [3:0]                    device_id,
	output logic                               q_valid,
	output gpra_pkg::item_t                    q_item,
	input  wire logic                          q_pop
);

	gpra_pkg::item_t fifo_q [2];
	gpra_pkg::item_t item_d;
	gpra_pkg::op_t   op_d;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	logic            push;

	always_comb begin
		unique case (kind)
			3'd0: op_d = gpra_pkg::OP_ADD_RAM;
			3'd1: op_d = gpra_pkg::OP_ADD_ROM;
			3'd2: op_d = gpra_pkg::OP_ADD_DEV;
			3'd3: op_d = (access_len == 4'd0) ? gpra_pkg::OP_NONE : gpra_pkg::OP_READ;
			3'd4: op_d = (access_len == 4'd0) ? gpra_pkg::OP_NONE : gpra_pkg::OP_WRITE;
			3'd5: op_d = gpra_pkg::OP_FETCH;
			3'd6: op_d = gpra_pkg::OP_MARK;
			default: op_d = gpra_pkg::OP_NONE;
		endcase
	end

	always_comb begin
		item_d.op          = op_d;
		item_d.address     = address;
		item_d.region_size = region_size;
		item_d.access_len  = access_len;
		item_d.device_id   = device_id;
	end

	assign in_ready = (cnt_q != 2'd2);
	assign push     = in_valid && in_ready;
	assign q_valid  = (cnt_q != 2'd0);
	assign q_item   = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= item_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

endmodule
`default_nettype wire

// ----- hdl/gpra_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gpra_back: region table, page records and access sequencer
// Carries out one queued item at a time: region adds with their page fill,
// and chunked accesses with page record read-modify-write.
// ----------------------------------------------------------------------------
module gpra_back (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             q_valid,
	input  wire gpra_pkg::item_t  q_item,
	output logic                  q_pop,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output gpra_pkg::result_t     res
);

	localparam int AB = gpra_pkg::AddrBits;
	localparam int RB = gpra_pkg::RegIdxBits;
	localparam int MR = gpra_pkg::MaxRegions;
	localparam int PS = gpra_pkg::PageShift;
	localparam int OB = gpra_pkg::OffBits;
	localparam int NB = gpra_pkg::NPageBits;
	localparam int PB = gpra_pkg::PageIdxBits;

	gpra_pkg::seq_state_t state_q, state_d;

	// Region table.
	logic [AB-1:0] base_q  [MR];
	logic [AB:0]   size_q  [MR];
	logic [MR-1:0] valid_q;
	logic [MR-1:0] isdev_q;
	logic [MR-1:0] wr_q;
	logic [3:0]    dev_q   [MR];
	logic [RB:0]   count_q;

	// Per-item working registers.
	gpra_pkg::item_t   cur_q;
	logic [AB-1:0]     addr_q;
	logic [3:0]        rem_q;
	logic              second_q;
	logic              hit_q;
	logic [RB-1:0]     g_q;
	logic [AB-1:0]     off_q;
	logic [AB:0]       room_q;
	logic [PB-1:0]     pg_q;
	logic [PB-1:0]     pg_last_q;
	logic              inval_q;
	logic [NB-1:0]     pc_q;
	logic [NB-1:0]     npg_q;
	logic [RB-1:0]     slot_q;
	logic              cont_q;
	gpra_pkg::result_t res_q;
	gpra_pkg::result_t out_q;
	logic              out_valid_q;

	// Page record memory.
	gpra_pkg::page_t                     mem [gpra_pkg::PageDepth];
	gpra_pkg::page_t                     rdata_q;
	logic                                mem_we;
	logic [gpra_pkg::PageAddrBits-1:0]   mem_waddr;
	gpra_pkg::page_t                     mem_wdata;
	logic [gpra_pkg::PageAddrBits-1:0]   mem_raddr;

	// Region lookup.
	logic          f_hit;
	logic [RB-1:0] f_g;
	logic [AB-1:0] f_off;
	logic [AB:0]   f_room;

	// Add checks.
	logic          a_backed;
	logic [AB+1:0] a_end;
	logic          a_overlap;
	logic [AB:0]   a_npages;
	logic          a_reject;

	// Chunk evaluation.
	logic [3:0]    e_chunk;
	logic [3:0]    e_rem_after;
	logic          e_last;
	logic          e_dev_ok;
	logic [OB-1:0] e_end;
	logic          is_wr;

	gpra_pkg::page_t   wb_rec;
	logic              wb_hit;
	gpra_pkg::result_t chunk_res;
	gpra_pkg::result_t res_d;
	logic              res_ld;
	logic              cont_d;
	logic              emit_go;

	always_comb begin
		f_hit = 1'b0;
		f_g   = '0;
		for (int i = MR - 1; i >= 0; i--) begin
			if (valid_q[i] && addr_q >= base_q[i] &&
			    {1'b0, addr_q - base_q[i]} < size_q[i]) begin
				f_hit = 1'b1;
				f_g   = RB'(i);
			end
		end
	end

	assign f_off  = addr_q - base_q[f_g];
	assign f_room = size_q[f_g] - {1'b0, f_off};

	assign a_backed = (cur_q.op == gpra_pkg::OP_ADD_RAM) || (cur_q.op == gpra_pkg::OP_ADD_ROM);
	assign a_end    = {2'b00, cur_q.address} + {1'b0, cur_q.region_size};
	assign a_npages = cur_q.region_size >> PS;

	always_comb begin
		a_overlap = 1'b0;
		for (int i = 0; i < MR; i++) begin
			if (valid_q[i]) begin
				if (cur_q.address >= base_q[i]) begin
					if ({1'b0, cur_q.address - base_q[i]} < size_q[i]) begin
						a_overlap = 1'b1;
					end
				end else if ({1'b0, base_q[i] - cur_q.address} < cur_q.region_size) begin
					a_overlap = 1'b1;
				end
			end
		end
	end

	assign a_reject = (cur_q.region_size == '0) ||
		(a_backed && ((cur_q.address[PS-1:0] != '0) || (cur_q.region_size[PS-1:0] != '0))) ||
		(a_end > gpra_pkg::AddrSpan) || a_overlap || (count_q >= (RB+1)'(MR)) ||
		(a_backed && (a_npages > {{(AB+1-NB){1'b0}}, NB'(gpra_pkg::PagesPerRegion)}));

	assign is_wr       = (cur_q.op == gpra_pkg::OP_WRITE);
	assign e_chunk     = (room_q < {{(AB-3){1'b0}}, rem_q}) ? room_q[3:0] : rem_q;
	assign e_rem_after = rem_q - e_chunk;
	assign e_last      = (e_rem_after == 4'd0) || second_q;
	assign e_end       = off_q[OB-1:0] + {{(OB-4){1'b0}}, e_chunk} - OB'(1);
	assign e_dev_ok    = (e_chunk == rem_q) &&
		(rem_q == 4'd1 || rem_q == 4'd2 || rem_q == 4'd4 || rem_q == 4'd8) &&
		((addr_q[3:0] & (rem_q - 4'd1)) == 4'd0);

	// A write marks the page dirty; a page that held code loses it and its
	// generation moves on.
	always_comb begin
		wb_rec       = rdata_q;
		wb_rec.dirty = 1'b1;
		wb_hit       = rdata_q.code;
		if (rdata_q.code) begin
			wb_rec.code = 1'b0;
			wb_rec.gen  = rdata_q.gen + gpra_pkg::GenBits'(1);
		end
	end

	always_comb begin
		chunk_res                  = '0;
		chunk_res.fault            = gpra_pkg::FAULT_NONE;
		chunk_res.fault_addr       = addr_q;
		chunk_res.write_access     = is_wr;
		chunk_res.region_index     = g_q;
		chunk_res.is_device        = isdev_q[g_q];
		chunk_res.target_device    = dev_q[g_q];
		chunk_res.offset           = off_q;
		chunk_res.chunk_len        = e_chunk;
		chunk_res.last             = e_last;
	end

	assign emit_go = (state_q == gpra_pkg::S_EMIT) && (!out_valid_q || res_ready);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			gpra_pkg::S_IDLE: begin
				if (q_valid) begin
					unique case (q_item.op)
						gpra_pkg::OP_ADD_RAM, gpra_pkg::OP_ADD_ROM,
						gpra_pkg::OP_ADD_DEV: state_d = gpra_pkg::S_ADD;
						gpra_pkg::OP_READ, gpra_pkg::OP_WRITE, gpra_pkg::OP_FETCH,
						gpra_pkg::OP_MARK: state_d = gpra_pkg::S_FIND;
						default: state_d = gpra_pkg::S_EMIT;
					endcase
				end
			end
			gpra_pkg::S_ADD: begin
				state_d = (a_reject || !a_backed) ? gpra_pkg::S_EMIT : gpra_pkg::S_FILL;
			end
			gpra_pkg::S_FILL: begin
				if (pc_q + NB'(1) == npg_q) begin
					state_d = gpra_pkg::S_EMIT;
				end
			end
			gpra_pkg::S_FIND: state_d = gpra_pkg::S_EVAL;
			gpra_pkg::S_EVAL: begin
				state_d = gpra_pkg::S_EMIT;
				unique case (cur_q.op)
					gpra_pkg::OP_WRITE: begin
						if (hit_q && !isdev_q[g_q] && wr_q[g_q]) begin
							state_d = gpra_pkg::S_PG_RD;
						end
					end
					gpra_pkg::OP_FETCH: begin
						if (hit_q && !isdev_q[g_q] &&
						    room_q >= {{(AB-2){1'b0}}, 3'd4}) begin
							state_d = gpra_pkg::S_PG_RD;
						end
					end
					gpra_pkg::OP_MARK: begin
						if (hit_q && !isdev_q[g_q]) begin
							state_d = gpra_pkg::S_PG_RD;
						end
					end
					default: state_d = gpra_pkg::S_EMIT;
				endcase
			end
			gpra_pkg::S_PG_RD: state_d = gpra_pkg::S_PG_WB;
			gpra_pkg::S_PG_WB: begin
				state_d = (is_wr && pg_q != pg_last_q) ? gpra_pkg::S_PG_RD : gpra_pkg::S_EMIT;
			end
			gpra_pkg::S_EMIT: begin
				if (emit_go) begin
					state_d = cont_q ? gpra_pkg::S_FIND : gpra_pkg::S_IDLE;
				end
			end
			default: state_d = gpra_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer: result build and page memory strobes.
	always_comb begin
		res_ld    = 1'b0;
		res_d     = '0;
		cont_d    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = {g_q, pg_q};
		mem_wdata = wb_rec;
		mem_raddr = {g_q, pg_q};
		q_pop     = 1'b0;
		unique case (state_q)
			gpra_pkg::S_IDLE: begin
				q_pop = q_valid;
				if (q_valid && q_item.op == gpra_pkg::OP_NONE) begin
					res_ld     = 1'b1;
					res_d.last = 1'b1;
				end
			end
			gpra_pkg::S_ADD: begin
				res_ld     = 1'b1;
				res_d.last = 1'b1;
				if (a_reject) begin
					res_d.fault      = gpra_pkg::FAULT_REJECT;
					res_d.fault_addr = cur_q.address;
				end
			end
			gpra_pkg::S_FILL: begin
				mem_we         = 1'b1;
				mem_waddr      = {slot_q, pc_q[PB-1:0]};
				mem_wdata      = '0;
				mem_wdata.exec = 1'b1;
			end
			gpra_pkg::S_EVAL: begin
				res_d.last       = 1'b1;
				res_d.fault_addr = addr_q;
				unique case (cur_q.op)
					gpra_pkg::OP_READ, gpra_pkg::OP_WRITE: begin
						res_d.write_access = is_wr;
						if (!hit_q) begin
							res_ld      = 1'b1;
							res_d.fault = gpra_pkg::FAULT_UNMAPPED;
						end else if (isdev_q[g_q]) begin
							res_ld = 1'b1;
							if (e_dev_ok) begin
								res_d      = chunk_res;
								res_d.last = 1'b1;
							end else begin
								res_d.fault = gpra_pkg::FAULT_MMIO;
							end
						end else if (is_wr && !wr_q[g_q]) begin
							res_ld      = 1'b1;
							res_d.fault = gpra_pkg::FAULT_PERM;
						end else if (!is_wr) begin
							res_ld = 1'b1;
							res_d  = chunk_res;
							cont_d = !e_last;
						end
					end
					gpra_pkg::OP_FETCH: begin
						if (!hit_q || isdev_q[g_q] ||
						    room_q < {{(AB-2){1'b0}}, 3'd4}) begin
							res_ld             = 1'b1;
							res_d.fault        = gpra_pkg::FAULT_UNMAPPED;
							res_d.fetch_access = 1'b1;
						end
					end
					default: begin
						if (!hit_q || isdev_q[g_q]) begin
							res_ld = 1'b1;
							res_d  = '0;
							res_d.last = 1'b1;
						end
					end
				endcase
			end
			gpra_pkg::S_PG_WB: begin
				unique case (cur_q.op)
					gpra_pkg::OP_WRITE: begin
						mem_we = 1'b1;
						if (pg_q == pg_last_q) begin
							res_ld                 = 1'b1;
							res_d                  = chunk_res;
							res_d.code_invalidated = inval_q || wb_hit;
							cont_d                 = !e_last;
						end
					end
					gpra_pkg::OP_FETCH: begin
						res_ld = 1'b1;
						if (rdata_q.exec) begin
							res_d              = chunk_res;
							res_d.write_access = 1'b0;
							res_d.chunk_len    = 4'd4;
							res_d.last         = 1'b1;
						end else begin
							res_d.fault      = gpra_pkg::FAULT_PERM;
							res_d.fault_addr = addr_q;
							res_d.last       = 1'b1;
						end
						res_d.fetch_access = 1'b1;
					end
					default: begin
						mem_we         = 1'b1;
						mem_wdata      = rdata_q;
						mem_wdata.code = 1'b1;
						res_ld         = 1'b1;
						res_d.last     = 1'b1;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= mem[mem_raddr];
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q    <= q_item;
			addr_q   <= q_item.address;
			rem_q    <= q_item.access_len;
			second_q <= 1'b0;
			inval_q  <= 1'b0;
		end
		if (state_q == gpra_pkg::S_FIND) begin
			hit_q  <= f_hit;
			g_q    <= f_g;
			off_q  <= f_off;
			room_q <= f_room;
		end
		if (state_q == gpra_pkg::S_EVAL) begin
			pg_q      <= off_q[OB-1:PS];
			pg_last_q <= e_end[OB-1:PS];
		end
		// The code flag gathers over the pages of one chunk and starts over
		// when a further chunk follows.
		if (state_q == gpra_pkg::S_PG_WB) begin
			inval_q <= (inval_q || wb_hit) && !(res_ld && cont_d);
			pg_q    <= pg_q + PB'(1);
		end
		if (state_q == gpra_pkg::S_ADD) begin
			slot_q <= count_q[RB-1:0];
			pc_q   <= '0;
			npg_q  <= cur_q.region_size[PS+NB-1:PS];
		end
		if (state_q == gpra_pkg::S_FILL) begin
			pc_q <= pc_q + NB'(1);
		end
		if (res_ld) begin
			res_q <= res_d;
		end
		// The next chunk starts where this one ends, wrapping at the top.
		if (res_ld && cont_d) begin
			addr_q   <= addr_q + {{(AB-4){1'b0}}, e_chunk};
			rem_q    <= e_rem_after;
			second_q <= 1'b1;
		end
		if (emit_go) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= gpra_pkg::S_IDLE;
			cont_q      <= 1'b0;
			out_valid_q <= 1'b0;
			valid_q     <= '0;
			isdev_q     <= '0;
			wr_q        <= '0;
			count_q     <= '0;
			for (int i = 0; i < MR; i++) begin
				base_q[i] <= '0;
				size_q[i] <= '0;
				dev_q[i]  <= '0;
			end
		end else begin
			state_q <= state_d;
			if (res_ld) begin
				cont_q <= cont_d;
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
			if (state_q == gpra_pkg::S_ADD && !a_reject) begin
				base_q[count_q[RB-1:0]]  <= cur_q.address;
				size_q[count_q[RB-1:0]]  <= cur_q.region_size;
				valid_q[count_q[RB-1:0]] <= 1'b1;
				isdev_q[count_q[RB-1:0]] <= !a_backed;
				wr_q[count_q[RB-1:0]]    <= (cur_q.op != gpra_pkg::OP_ADD_ROM);
				dev_q[count_q[RB-1:0]]   <= a_backed ? 4'd0 : cur_q.device_id;
				count_q                  <= count_q + (RB+1)'(1);
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule
`default_nettype wire

// ----- hdl/guest_phys_region_access_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// guest_phys_region_access_checker: guest physical memory map checker
// Keeps a table of RAM, ROM and device regions with per-page flags and
// reports the chunks and faults of each access.
// ----------------------------------------------------------------------------
// Usage:
// Items enter on in_valid/in_ready; result items leave on out_valid/out_ready,
// each item giving one or two results, the final one flagged by last.
// Items land in a two-entry queue, so up to two can be taken while the
// sequencer is busy. The sequencer works on one item at a time:
//   no-op or zero-length access: result built while the item is taken;
//   region add: checks, then for RAM and ROM a page fill, which writes one
//   record per cycle through the single write port;
//   read or device chunk: region lookup, then chunk evaluation, per chunk;
//   write chunk: the same plus a read-modify-write of each page touched in the
//   page memory; fetch and mark code: one page record access unless a check fails.
// Reset empties the region table and queue; page records need no clearing
// because every page is filled when its region is added.
// A stalled receiver holds the result in the output register; the sequencer
// then waits on its next result while the queue takes items until it is full.
// ----------------------------------------------------------------------------
module guest_phys_region_access_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [2:0]                    kind,
	input  wire logic [gpra_pkg::AddrBits-1:0] address,
	input  wire logic [gpra_pkg::AddrBits:0]   region_size,
	input  wire logic [3:0]                    access_len,
	input  wire logic [3:0]                    device_id,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [2:0]                         fault_kind,
	output logic [gpra_pkg::AddrBits-1:0]      fault_addr,
	output logic                               write_access,
	output logic                               fetch_access,
	output logic [gpra_pkg::RegIdxBits-1:0]    region_index,
	output logic                               is_device,
	output logic [3:0]                         target_device,
	output logic [gpra_pkg::AddrBits-1:0]      offset,
	output logic [3:0]                         chunk_len,
	output logic                               code_invalidated,
	output logic                               last
);

	logic              q_valid;
	logic              q_pop;
	gpra_pkg::item_t   q_item;
	gpra_pkg::result_t res;

	gpra_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.kind        (kind),
		.address     (address),
		.region_size (region_size),
		.access_len  (access_len),
		.device_id   (device_id),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	gpra_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.q_pop     (q_pop),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res       (res)
	);

	assign fault_kind       = res.fault;
	assign fault_addr       = res.fault_addr;
	assign write_access     = res.write_access;
	assign fetch_access     = res.fetch_access;
	assign region_index     = res.region_index;
	assign is_device        = res.is_device;
	assign target_device    = res.target_device;
	assign offset           = res.offset;
	assign chunk_len        = res.chunk_len;
	assign code_invalidated = res.code_invalidated;
	assign last             = res.last;

`ifndef SYNTH
	// A fault always ends the item.
	a_fault_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault_kind != gpra_pkg::FAULT_NONE |-> last)
		else $error("fault result without last");

	// A device chunk is always the final part of an access.
	a_device_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_device && fault_kind == gpra_pkg::FAULT_NONE |-> last)
		else $error("device chunk not last");

	// A successful fetch always covers four bytes.
	a_fetch_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fetch_access && fault_kind == gpra_pkg::FAULT_NONE |-> chunk_len == 4'd4)
		else $error("fetch chunk length wrong");
`endif

endmodule
`default_nettype wire

// ----- tb/gpra_result_checker.sv -----
// ----------------------------------------------------------------------------
// gpra_result_checker: region map predictor and result comparator
// Watches both channels of the region access checker, keeps its own copy of
// the region table and page records, predicts the results of every accepted
// item and compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module gpra_result_checker (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	input  wire logic                            in_ready,
	input  wire logic [2:0]                      kind,
	input  wire logic [gpra_pkg::AddrBits-1:0]   address,
	input  wire logic [gpra_pkg::AddrBits:0]     region_size,
	input  wire logic [3:0]                      access_len,
	input  wire logic [3:0]                      device_id,
	input  wire logic                            out_valid,
	input  wire logic                            out_ready,
	input  wire logic [2:0]                      fault_kind,
	input  wire logic [gpra_pkg::AddrBits-1:0]   fault_addr,
	input  wire logic                            write_access,
	input  wire logic                            fetch_access,
	input  wire logic [gpra_pkg::RegIdxBits-1:0] region_index,
	input  wire logic                            is_device,
	input  wire logic [3:0]                      target_device,
	input  wire logic [gpra_pkg::AddrBits-1:0]   offset,
	input  wire logic [3:0]                      chunk_len,
	input  wire logic                            code_invalidated,
	input  wire logic                            last,
	output int                                   fail_count,
	output int                                   pending
);

	localparam int AB  = gpra_pkg::AddrBits;
	localparam int MR  = gpra_pkg::MaxRegions;
	localparam int PPR = gpra_pkg::PagesPerRegion;
	localparam int PS  = gpra_pkg::PageShift;
	localparam logic [63:0] AddrMask = (64'd1 << AB) - 1;

	logic [63:0]       map_base [MR];
	logic [63:0]       map_size [MR];
	logic              map_valid [MR];
	logic              map_dev [MR];
	logic              map_wr [MR];
	logic [3:0]        map_id [MR];
	int                map_count;
	gpra_pkg::page_t   pages [gpra_pkg::PageDepth];
	gpra_pkg::result_t expected_results[$];

	function automatic int region_of(logic [63:0] a);
		for (int i = 0; i < map_count && i < MR; i++)
			if (map_valid[i] && a >= map_base[i] && a - map_base[i] < map_size[i])
				return i;
		return -1;
	endfunction

	function automatic gpra_pkg::result_t chunk_result(logic [63:0] a, logic w, logic f,
			int g, logic [63:0] off, logic [63:0] len, logic inval);
		gpra_pkg::result_t r;
		r = '0;
		r.fault = gpra_pkg::FAULT_NONE;
		r.fault_addr = a[AB-1:0];
		r.write_access = w;
		r.fetch_access = f;
		r.region_index = g[1:0];
		r.is_device = map_dev[g];
		r.target_device = map_id[g];
		r.offset = off[AB-1:0];
		r.chunk_len = len[3:0];
		r.code_invalidated = inval;
		return r;
	endfunction

	function automatic gpra_pkg::result_t fault_result(gpra_pkg::fault_t fk, logic [63:0] a,
			logic w, logic f);
		gpra_pkg::result_t r;
		r = '0;
		r.fault = fk;
		r.fault_addr = a[AB-1:0];
		r.write_access = w;
		r.fetch_access = f;
		return r;
	endfunction

	function automatic logic try_add(gpra_pkg::op_t k, logic [63:0] base, logic [63:0] sz,
			logic [3:0] dv);
		logic backed;
		logic [63:0] npg;
		int slot;
		backed = (k == gpra_pkg::OP_ADD_RAM) || (k == gpra_pkg::OP_ADD_ROM);
		if (sz == 0)
			return 1'b0;
		if (backed && (base[PS-1:0] != 0 || sz[PS-1:0] != 0))
			return 1'b0;
		if (base > AddrMask || sz - 1 > AddrMask - base)
			return 1'b0;
		for (int i = 0; i < map_count && i < MR; i++) begin
			if (!map_valid[i])
				continue;
			if (base >= map_base[i] ? (base - map_base[i] < map_size[i])
					: (map_base[i] - base < sz))
				return 1'b0;
		end
		if (map_count >= MR)
			return 1'b0;
		npg = backed ? sz >> PS : 64'd0;
		if (npg > PPR)
			return 1'b0;
		slot = map_count;
		map_base[slot] = base;
		map_size[slot] = sz;
		map_valid[slot] = 1'b1;
		map_dev[slot] = !backed;
		map_wr[slot] = (k != gpra_pkg::OP_ADD_ROM);
		map_id[slot] = backed ? 4'd0 : dv;
		for (int p = 0; p < npg; p++)
			pages[slot*PPR + p] = '{code: 1'b0, dirty: 1'b0, exec: 1'b1, gen: '0};
		map_count++;
		return 1'b1;
	endfunction

	task automatic predict_item(gpra_pkg::op_t k, logic [63:0] a, logic [63:0] sz,
			logic [63:0] len, logic [3:0] dv);
		gpra_pkg::result_t r[2];
		int n;
		int g;
		logic w;
		logic inval;
		logic [63:0] rem, off, chunk, pfirst, plast, pg;
		gpra_pkg::page_t pr;
		r[0] = '0;
		r[1] = '0;
		n = 0;
		case (k)
			gpra_pkg::OP_ADD_RAM, gpra_pkg::OP_ADD_ROM, gpra_pkg::OP_ADD_DEV: begin
				if (!try_add(k, a, sz, dv))
					r[0] = fault_result(gpra_pkg::FAULT_REJECT, a, 1'b0, 1'b0);
				n = 1;
			end
			gpra_pkg::OP_READ, gpra_pkg::OP_WRITE: begin
				w = (k == gpra_pkg::OP_WRITE);
				rem = len;
				while (rem > 0 && n < 2) begin
					g = region_of(a);
					inval = 1'b0;
					if (g < 0) begin
						r[n] = fault_result(gpra_pkg::FAULT_UNMAPPED, a, w, 1'b0);
						n++;
						break;
					end
					off = a - map_base[g];
					chunk = map_size[g] - off;
					if (chunk > rem)
						chunk = rem;
					if (map_dev[g]) begin
						// A device access must be the whole remainder, a power-of-two
						// size up to eight, and naturally aligned.
						if (chunk != rem || !(rem == 1 || rem == 2 || rem == 4 || rem == 8)
								|| (a & (rem - 1)) != 0)
							r[n] = fault_result(gpra_pkg::FAULT_MMIO, a, w, 1'b0);
						else
							r[n] = chunk_result(a, w, 1'b0, g, off, chunk, 1'b0);
						n++;
						break;
					end
					if (w) begin
						if (!map_wr[g]) begin
							r[n] = fault_result(gpra_pkg::FAULT_PERM, a, w, 1'b0);
							n++;
							break;
						end
						pfirst = off >> PS;
						plast = (off + chunk - 1) >> PS;
						for (pg = pfirst; pg <= plast && pg < PPR; pg++) begin
							pr = pages[g*PPR + pg];
							pr.dirty = 1'b1;
							if (pr.code) begin
								pr.code = 1'b0;
								pr.gen = pr.gen + 1;
								inval = 1'b1;
							end
							pages[g*PPR + pg] = pr;
						end
					end
					r[n] = chunk_result(a, w, 1'b0, g, off, chunk, inval);
					n++;
					a = (a + chunk) & AddrMask;
					rem = rem - chunk;
				end
			end
			gpra_pkg::OP_FETCH: begin
				g = region_of(a);
				if (g < 0 || map_dev[g])
					r[0] = fault_result(gpra_pkg::FAULT_UNMAPPED, a, 1'b0, 1'b1);
				else begin
					off = a - map_base[g];
					pg = off >> PS;
					if (map_size[g] - off < 4)
						r[0] = fault_result(gpra_pkg::FAULT_UNMAPPED, a, 1'b0, 1'b1);
					else if (pg >= PPR || !pages[g*PPR + pg].exec)
						r[0] = fault_result(gpra_pkg::FAULT_PERM, a, 1'b0, 1'b1);
					else
						r[0] = chunk_result(a, 1'b0, 1'b1, g, off, 64'd4, 1'b0);
				end
				n = 1;
			end
			gpra_pkg::OP_MARK: begin
				g = region_of(a);
				if (g >= 0 && !map_dev[g]) begin
					pg = (a - map_base[g]) >> PS;
					if (pg < PPR)
						pages[g*PPR + pg].code = 1'b1;
				end
				n = 1;
			end
			default: n = 0;
		endcase
		if (n == 0)
			n = 1;
		r[n-1].last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_results = {expected_results, r[i]};
	endtask

	always @(posedge clk or negedge arst_n) begin
		gpra_pkg::result_t seen, want;
		if (!arst_n) begin
			for (int i = 0; i < MR; i++) begin
				map_base[i] = '0;
				map_size[i] = '0;
				map_valid[i] = 1'b0;
				map_dev[i] = 1'b0;
				map_wr[i] = 1'b0;
				map_id[i] = '0;
			end
			map_count = 0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			// Results are checked before the new item is predicted; an item
			// accepted now cannot have produced a result yet.
			if (out_valid && out_ready) begin
				seen = '{fault: gpra_pkg::fault_t'(fault_kind), fault_addr: fault_addr,
					write_access: write_access, fetch_access: fetch_access,
					region_index: region_index, is_device: is_device,
					target_device: target_device, offset: offset, chunk_len: chunk_len,
					code_invalidated: code_invalidated, last: last};
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result item: %p", seen);
				end else begin
					want = expected_results.pop_front();
					if (seen !== want) begin
						fail_count++;
						if (fail_count <= 10)
							$display("result mismatch:\n  expected %p\n  actual   %p", want, seen);
					end
				end
			end
			if (in_valid && in_ready)
				predict_item(gpra_pkg::op_t'(kind), {16'd0, address}, {15'd0, region_size},
					{60'd0, access_len}, device_id);
		end
		pending = expected_results.size();
	end

endmodule

// ----- tb/guest_phys_region_access_checker_test.sv -----
// ----------------------------------------------------------------------------
// guest_phys_region_access_checker_test: testbench top
// Builds a four-region map (with rejected adds of every kind), runs directed
// corner accesses and then random accesses around region and page edges,
// with random idle bursts on both channels; a checker module scores results.
// ----------------------------------------------------------------------------
module guest_phys_region_access_checker_test;

	localparam int CycleLimit = 600000;
	localparam int AB = gpra_pkg::AddrBits;
	localparam logic [47:0] TopBase = 48'hFFFF_FFF0_0000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic [2:0]          kind = '0;
	logic [AB-1:0]       address = '0;
	logic [AB:0]         region_size = '0;
	logic [3:0]          access_len = '0;
	logic [3:0]          device_id = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [2:0]          fault_kind;
	logic [AB-1:0]       fault_addr;
	logic                write_access, fetch_access, is_device, code_invalidated, last;
	logic [1:0]          region_index;
	logic [3:0]          target_device, chunk_len;
	logic [AB-1:0]       offset;
	int                  fail_count, pending;
	int                  cycles = 0;
	logic                no_idle = 1'b0;
	int                  sink_stall = 0;

	logic [47:0] map_lo [4] = '{48'h0, 48'h4_0000, 48'h8_0000, TopBase};
	logic [47:0] map_len [4] = '{48'h1_0000, 48'h2000, 48'h40, 48'h10_0000};

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	guest_phys_region_access_checker i_dut (.*);

	gpra_result_checker i_checker (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Receiver: random stall bursts, none once the final stretch starts.
	always @(posedge clk) begin
		if (no_idle)
			out_ready <= 1'b1;
		else if (sink_stall > 0) begin
			sink_stall <= sink_stall - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			sink_stall <= $urandom_range(0, 5);
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	task automatic send(gpra_pkg::op_t k, logic [47:0] a, logic [48:0] sz, logic [3:0] ln,
			logic [3:0] dv);
		in_valid <= 1'b1;
		kind <= k;
		address <= a;
		region_size <= sz;
		access_len <= ln;
		device_id <= dv;
		do @(posedge clk); while (!in_ready);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// Mostly near region and page edges, sometimes anywhere.
	function automatic logic [47:0] pick_address();
		int g;
		logic [47:0] off;
		g = $urandom_range(0, 3);
		case ($urandom_range(0, 9))
			0, 1: return 48'({$urandom, $urandom});
			2, 3, 4: off = 48'({$urandom_range(0, map_len[g] >> 12), 12'd0})
				+ 48'($urandom_range(0, 16)) - 48'd8;
			5: off = map_len[g] - 48'($urandom_range(0, 12));
			default: off = 48'($urandom_range(0, map_len[g] - 1));
		endcase
		return map_lo[g] + off;
	endfunction

	initial begin
		gpra_pkg::op_t k;
		int sel;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Rejected adds: zero size, too many pages, misaligned, overflow.
		send(gpra_pkg::OP_ADD_RAM, 48'h0, 49'h0, 4'd0, 4'd0);
		send(gpra_pkg::OP_ADD_RAM, 48'h0, 49'h1_0000_0000_0000, 4'd0, 4'd0);
		send(gpra_pkg::OP_ADD_RAM, 48'h800, 49'h1000, 4'd0, 4'd0);
		send(gpra_pkg::OP_ADD_DEV, 48'h1, 49'h1_0000_0000_0000, 4'd0, 4'd15);
		send(gpra_pkg::OP_ADD_RAM, map_lo[0], 49'(map_len[0]), 4'd0, 4'd0);
		send(gpra_pkg::OP_ADD_RAM, 48'h8000, 49'h1_0000, 4'd0, 4'd0);
		send(gpra_pkg::OP_ADD_RAM, 48'h20_0000, 49'h10_1000, 4'd0, 4'd0);
		send(gpra_pkg::OP_ADD_ROM, map_lo[1], 49'(map_len[1]), 4'd0, 4'd3);
		send(gpra_pkg::OP_ADD_DEV, map_lo[2], 49'(map_len[2]), 4'd0, 4'd9);
		// Largest backed region, ending exactly at the top of the address space.
		send(gpra_pkg::OP_ADD_RAM, map_lo[3], 49'(map_len[3]), 4'd0, 4'd0);
		send(gpra_pkg::OP_ADD_DEV, 48'h9_0000, 49'h10, 4'd0, 4'd6);

		send(gpra_pkg::OP_READ, 48'h0FF8, 49'h0, 4'd8, 4'd0);
		send(gpra_pkg::OP_READ, 48'hFFFC, 49'h0, 4'd8, 4'd0);
		send(gpra_pkg::OP_READ, 48'h100, 49'h0, 4'd0, 4'd0);
		send(gpra_pkg::OP_WRITE, map_lo[1], 49'h0, 4'd4, 4'd0);
		send(gpra_pkg::OP_MARK, 48'h1000, 49'h0, 4'd0, 4'd0);
		send(gpra_pkg::OP_WRITE, 48'h0FFE, 49'h0, 4'd4, 4'd0);
		send(gpra_pkg::OP_FETCH, 48'h1000, 49'h0, 4'd0, 4'd0);
		send(gpra_pkg::OP_FETCH, 48'hFFFE, 49'h0, 4'd0, 4'd0);
		send(gpra_pkg::OP_FETCH, map_lo[2], 49'h0, 4'd4, 4'd0);
		send(gpra_pkg::OP_FETCH, 48'h7000_0000, 49'h0, 4'd4, 4'd0);
		send(gpra_pkg::OP_READ, 48'h8_0008, 49'h0, 4'd8, 4'd0);
		send(gpra_pkg::OP_WRITE, 48'h8_0004, 49'h0, 4'd8, 4'd0);
		send(gpra_pkg::OP_READ, 48'h8_0010, 49'h0, 4'd3, 4'd0);
		send(gpra_pkg::OP_READ, 48'h8_003C, 49'h0, 4'd8, 4'd0);
		send(gpra_pkg::OP_WRITE, 48'hFFFF_FFFF_FFFC, 49'h0, 4'd8, 4'd0);
		send(gpra_pkg::OP_NONE, 48'hFFFF_FFFF_FFFF, 49'h1_FFFF_FFFF_FFFF, 4'd15, 4'd15);
		send(gpra_pkg::OP_READ, 48'h20, 49'h0, 4'd15, 4'd0);

		for (int i = 0; i < 850; i++) begin
			if (i == 750)
				no_idle = 1'b1;
			sel = $urandom_range(0, 99);
			if (sel < 30) k = gpra_pkg::OP_WRITE;
			else if (sel < 55) k = gpra_pkg::OP_READ;
			else if (sel < 70) k = gpra_pkg::OP_FETCH;
			else if (sel < 85) k = gpra_pkg::OP_MARK;
			else if (sel < 93) k = gpra_pkg::op_t'($urandom_range(0, 2));
			else k = gpra_pkg::OP_NONE;
			send(k, pick_address(), 49'({$urandom_range(0, 1), $urandom, $urandom}),
				4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
		end
		in_valid <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
